@@ sv/nearest_center_assignment_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nearest center assignment block
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTER_ASSIGNMENT_DEFINES_SVH
`define NEAREST_CENTER_ASSIGNMENT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked at each rising clock edge, switched off while reset is high.
`define NCA_ASSERT(lbl, pclk, prst, prop, msg) \
  lbl: assert property (@(posedge pclk) disable iff (prst) prop) else $error(msg);
// Checked at each rising clock edge, reset included.
`define NCA_ASSERT_NORST(lbl, pclk, prop, msg) \
  lbl: assert property (@(posedge pclk) prop) else $error(msg);
`else
`define NCA_ASSERT(lbl, pclk, prst, prop, msg)
`define NCA_ASSERT_NORST(lbl, pclk, prop, msg)
`endif
`endif

@@ sv/nca_pkg.sv @@
// ----------------------------------------------------------------------------
// Nearest center assignment package
// Shared widths, register and request codes, and the request, result and
// chain token types.
// ----------------------------------------------------------------------------
package nca_pkg;

  // Field widths.
  localparam int COORD_W  = 16;
  localparam int SLOT_W   = 4;
  localparam int CENTER_W = 4;
  localparam int DIST_W   = 36;
  localparam int CFG_W    = 5;

  // Configuration port widths.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Default sizes of the center store.
  localparam int DEF_MAX_CENTERS = 16;
  localparam int DEF_MAX_DIMS    = 16;

  // Register reset value for both count registers.
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Register index, taken from address bit 2.
  localparam logic REG_CENTERS = 1'b0;
  localparam logic REG_DIMS    = 1'b1;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  // One request as it arrives.
  typedef struct packed {
    logic                      req_type;
    logic [SLOT_W-1:0]         center_slot;
    logic [SLOT_W-1:0]         coord_slot;
    logic signed [COORD_W-1:0] coord_value;
  } nca_req_t;

  // One result.
  typedef struct packed {
    logic [CENTER_W-1:0] best_center;
    logic [DIST_W-1:0]   best_distance;
  } nca_result_t;

  // Token handed from cell to cell along the chain.
  typedef struct packed {
    logic                      valid;
    logic                      point;
    logic                      load_ok;
    logic                      last;
    logic [SLOT_W-1:0]         center_slot;
    logic signed [COORD_W-1:0] coord_value;
    logic [DIST_W-1:0]         best_dist;
  } nca_tok_t;

endpackage

@@ sv/nca_cell.sv @@
// ----------------------------------------------------------------------------
// Nearest center assignment cell
// Holds the coordinates and the running distance of one center. A request
// passes through four stages: store access, squared difference,
// accumulation, and update of the best center carried by the token.
// ----------------------------------------------------------------------------
module nca_cell #(
  parameter int MAX_DIMS = nca_pkg::DEF_MAX_DIMS,
  parameter int CELL_IDX = 0,
  parameter int DIM_W    = 4,
  parameter int IDX_W    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                active,
  input  nca_pkg::nca_tok_t   tok_in,
  input  logic [DIM_W-1:0]    addr_in,
  input  logic [IDX_W-1:0]    idx_in,
  output nca_pkg::nca_tok_t   tok_out,
  output logic [DIM_W-1:0]    addr_out,
  output logic [IDX_W-1:0]    idx_out
);

  localparam int SQ_W = 2 * nca_pkg::COORD_W;

  // Coordinate store of this center, undefined until loaded.
  logic signed [nca_pkg::COORD_W-1:0] mem [MAX_DIMS];
  logic signed [nca_pkg::COORD_W-1:0] coord_q;

  // Stage registers.
  nca_pkg::nca_tok_t          tok1, tok2, tok3, tok4;
  logic [DIM_W-1:0]           addr1, addr2, addr3, addr4;
  logic [IDX_W-1:0]           idx1, idx2, idx3, idx4;
  logic [SQ_W-1:0]            sq2;
  logic [nca_pkg::DIST_W-1:0] sum3;
  logic [nca_pkg::DIST_W-1:0] acc;

  // Combinational values between stages.
  logic                         wr_en;
  logic signed [nca_pkg::COORD_W:0] diff;
  logic [nca_pkg::COORD_W:0]    diff_abs;
  logic [nca_pkg::COORD_W-1:0]  mag;
  logic [SQ_W-1:0]              sq;
  logic [nca_pkg::DIST_W:0]     acc_sum;
  logic [nca_pkg::DIST_W-1:0]   acc_sat;
  logic                         take;
  nca_pkg::nca_tok_t            tok3_upd;

  assign wr_en = tok_in.valid && tok_in.load_ok &&
                 (32'(tok_in.center_slot) == CELL_IDX);

  // Store write by a load and registered read for a point.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_en) begin
        mem[addr_in] <= tok_in.coord_value;
      end
      coord_q <= mem[addr_in];
    end
  end

  // Squared difference; the magnitude always fits the coordinate width.
  assign diff     = {tok1.coord_value[nca_pkg::COORD_W-1], tok1.coord_value} -
                    {coord_q[nca_pkg::COORD_W-1], coord_q};
  assign diff_abs = diff[nca_pkg::COORD_W] ? (-diff) : diff;
  assign mag      = diff_abs[nca_pkg::COORD_W-1:0];
  assign sq       = SQ_W'(mag) * SQ_W'(mag);

  // Saturating accumulation.
  assign acc_sum = {1'b0, acc} + (nca_pkg::DIST_W + 1)'(sq2);
  assign acc_sat = acc_sum[nca_pkg::DIST_W] ? '1 : acc_sum[nca_pkg::DIST_W-1:0];

  // A finished point takes this center when it is the first one, or when this
  // center is in use and strictly nearer than the best so far.
  assign take = tok3.valid && tok3.point && tok3.last &&
                ((CELL_IDX == 0) || (active && (sum3 < tok3.best_dist)));

  // Token for the next cell, carrying this distance when this center wins.
  always_comb begin
    tok3_upd = tok3;
    if (take) begin
      tok3_upd.best_dist = sum3;
    end
  end

  // Pipeline stages and the running distance.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok1.valid <= 1'b0;
      tok2.valid <= 1'b0;
      tok3.valid <= 1'b0;
      tok4.valid <= 1'b0;
      acc        <= '0;
    end else if (adv) begin
      tok1  <= tok_in;
      addr1 <= addr_in;
      idx1  <= idx_in;

      tok2  <= tok1;
      addr2 <= addr1;
      idx2  <= idx1;
      sq2   <= sq;

      tok3  <= tok2;
      addr3 <= addr2;
      idx3  <= idx2;
      sum3  <= acc_sat;
      if (tok2.valid && tok2.point) begin
        acc <= tok2.last ? '0 : acc_sat;
      end

      tok4  <= tok3_upd;
      addr4 <= addr3;
      idx4  <= take ? IDX_W'(CELL_IDX) : idx3;
    end
  end

  assign tok_out  = tok4;
  assign addr_out = addr4;
  assign idx_out  = idx4;

endmodule

@@ sv/nearest_center_assignment.sv @@
// ----------------------------------------------------------------------------
// Nearest center assignment
// Finds the nearest loaded center of each streamed point by squared
// Euclidean distance, with a chain of one cell per center.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while req_stall is low: loads
// write one coordinate of one center, points bring one coordinate each in
// order. Every request walks the chain of MAX_CENTERS cells, four pipeline
// stages per cell, and the result for a point is registered at the tail of
// the chain once its last coordinate has passed every cell. While a result
// waits with result_stall high the whole chain holds and req_stall is high.
// The center store has no reset: load every coordinate in use before the
// first point. Ties go to the lower center index.
module nearest_center_assignment #(
  parameter int MAX_CENTERS = nca_pkg::DEF_MAX_CENTERS,
  parameter int MAX_DIMS    = nca_pkg::DEF_MAX_DIMS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  nca_pkg::nca_req_t            req,
  input  logic                         req_valid,
  output logic                         req_stall,
  output nca_pkg::nca_result_t         result,
  output logic                         result_valid,
  input  logic                         result_stall,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nca_pkg::PADDR_W-1:0]  paddr,
  input  logic [nca_pkg::PDATA_W-1:0]  pwdata,
  output logic [nca_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  `include "nearest_center_assignment_defines.svh"

  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W = $clog2(MAX_DIMS + 1);
  localparam int IDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

  logic [nca_pkg::CFG_W-1:0] centers_in_use;
  logic [nca_pkg::CFG_W-1:0] dims_in_use;
  logic [DIM_W-1:0]          coord_counter;

  logic                      adv;
  logic                      is_point;
  logic [CNT_W-1:0]          cnt1;
  logic                      req_last;
  logic                      req_load_ok;

  nca_pkg::nca_tok_t         tok_chain  [MAX_CENTERS+1];
  logic [DIM_W-1:0]          addr_chain [MAX_CENTERS+1];
  logic [IDX_W-1:0]          idx_chain  [MAX_CENTERS+1];
  logic                      tail_final;

  // Register access; the index is address bit 2.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centers_in_use <= nca_pkg::CFG_RESET;
      dims_in_use    <= nca_pkg::CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        nca_pkg::REG_CENTERS: centers_in_use <= pwdata[nca_pkg::CFG_W-1:0];
        nca_pkg::REG_DIMS:    dims_in_use    <= pwdata[nca_pkg::CFG_W-1:0];
        default:              centers_in_use <= centers_in_use;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nca_pkg::REG_CENTERS: prdata = nca_pkg::PDATA_W'(centers_in_use);
      nca_pkg::REG_DIMS:    prdata = nca_pkg::PDATA_W'(dims_in_use);
      default:              prdata = '0;
    endcase
  end

  // The chain advances unless a result is held by the receiver.
  assign adv       = !(result_valid && result_stall);
  assign req_stall = !adv;

  // Coordinate count of the current point; a count register of zero acts as
  // one and one above the store depth acts as the depth.
  assign is_point    = (req.req_type == nca_pkg::REQ_POINT);
  assign cnt1        = CNT_W'(coord_counter) + CNT_W'(1);
  assign req_last    = (32'(cnt1) >= 32'(dims_in_use)) || (32'(cnt1) == MAX_DIMS);
  assign req_load_ok = !is_point &&
                       (32'(req.center_slot) < MAX_CENTERS) &&
                       (32'(req.coord_slot) < MAX_DIMS);

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_counter <= '0;
    end else if (req_valid && adv && is_point) begin
      coord_counter <= req_last ? '0 : DIM_W'(cnt1);
    end
  end

  // Head of the chain.
  always_comb begin
    tok_chain[0].valid       = req_valid;
    tok_chain[0].point       = is_point;
    tok_chain[0].load_ok     = req_load_ok;
    tok_chain[0].last        = req_last;
    tok_chain[0].center_slot = req.center_slot;
    tok_chain[0].coord_value = req.coord_value;
    tok_chain[0].best_dist   = '0;
    addr_chain[0]            = is_point ? coord_counter : DIM_W'(req.coord_slot);
    idx_chain[0]             = '0;
  end

  // One cell per center.
  for (genvar j = 0; j < MAX_CENTERS; j++) begin : g_cell
    logic active;
    assign active = (j == 0) || (32'(centers_in_use) > j);

    nca_cell #(
      .MAX_DIMS (MAX_DIMS),
      .CELL_IDX (j),
      .DIM_W    (DIM_W),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .active   (active),
      .tok_in   (tok_chain[j]),
      .addr_in  (addr_chain[j]),
      .idx_in   (idx_chain[j]),
      .tok_out  (tok_chain[j+1]),
      .addr_out (addr_chain[j+1]),
      .idx_out  (idx_chain[j+1])
    );
  end

  // Result register at the tail of the chain.
  assign tail_final = tok_chain[MAX_CENTERS].valid && tok_chain[MAX_CENTERS].point &&
                      tok_chain[MAX_CENTERS].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid         <= tail_final;
      result.best_center   <= nca_pkg::CENTER_W'(idx_chain[MAX_CENTERS]);
      result.best_distance <= tok_chain[MAX_CENTERS].best_dist;
    end
  end

  // Checks.
  `NCA_ASSERT_NORST(a_reset_clears, clk, rst |=> (!result_valid && coord_counter == '0), "reset did not clear the control state")
  `NCA_ASSERT(a_counter_range, clk, rst, 32'(coord_counter) < MAX_DIMS, "coordinate counter beyond store depth")
  `NCA_ASSERT(a_hold_counter, clk, rst, !adv |=> $stable(coord_counter), "coordinate counter moved while the chain held")
  `NCA_ASSERT(a_tail_result, clk, rst, (adv && tail_final) |=> result_valid, "finished point at chain tail gave no result")

endmodule
